// File: design/cbm_pkg.sv
package cbm_pkg;

    // Field widths
    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int PHYS_W      = 23;
    localparam int ROM_BANK_W  = 9;
    localparam int RAM_BANK_W  = 4;
    localparam int UPPER_W     = 2;
    localparam int ROM_OFS_W   = 14;   // 16 KiB ROM bank
    localparam int RAM_OFS_W   = 13;   // 8 KiB RAM bank
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    // Mapper codes
    localparam logic [2:0] MAP_NONE = 3'd0;
    localparam logic [2:0] MAP_MBC1 = 3'd1;
    localparam logic [2:0] MAP_MBC2 = 3'd2;
    localparam logic [2:0] MAP_MBC3 = 3'd3;
    localparam logic [2:0] MAP_MBC5 = 3'd4;

    // Target codes
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_ROM  = 2'd1;
    localparam logic [1:0] TGT_RAM  = 2'd2;
    localparam logic [1:0] TGT_OPEN = 2'd3;

    // Access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_TYPE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_PRESENT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_BITS = 2'd3;

    // Register write constants
    localparam logic [3:0] RAM_EN_KEY   = 4'hA;
    localparam logic [3:0] ROM_BITS_MAX = 4'd9;
    localparam logic [2:0] RAM_BITS_MAX = 3'd4;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] bus_address;
        logic [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic [1:0]        target;
        logic [PHYS_W-1:0] physical_address;
        logic              ram_write;
    } rsp_t;

    // Low-bit mask for a power-of-two ROM bank count, count capped at 2^9
    function automatic logic [ROM_BANK_W-1:0] rom_mask(input logic [3:0] bits);
        logic [3:0]            b;
        logic [ROM_BANK_W-1:0] m;
        b = (bits > ROM_BITS_MAX) ? ROM_BITS_MAX : bits;
        for (int i = 0; i < ROM_BANK_W; i++)
        begin
            m[i] = (4'(i) < b);
        end
        return m;
    endfunction

    // Same for RAM banks, count capped at 2^4
    function automatic logic [RAM_BANK_W-1:0] ram_mask(input logic [2:0] bits);
        logic [2:0]            b;
        logic [RAM_BANK_W-1:0] m;
        b = (bits > RAM_BITS_MAX) ? RAM_BITS_MAX : bits;
        for (int i = 0; i < RAM_BANK_W; i++)
        begin
            m[i] = (3'(i) < b);
        end
        return m;
    endfunction

endpackage

// File: design/cartridge_bank_mapper_unit.sv
// A request accepted on the input is held in the stage-1 register, then mapped into
// the result register, which drives out_data with out_valid high.
// Throughput: one request per cycle; the input register and the result register
// hold up to two requests, and in_ready drops only while both are full and out_ready is low.
// Reset (rst_n low, asynchronous): pipeline empties, configuration and bank
// registers return to defaults (no mapper, ROM bank 1, RAM disabled).
module cartridge_bank_mapper_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  cbm_pkg::req_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output cbm_pkg::rsp_t                      out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration
    logic [2:0] mapper_type_reg;
    logic [3:0] rom_bank_bits_reg;
    logic       ram_present_reg;
    logic [2:0] ram_bank_bits_reg;

    // Bank state
    logic                             ram_enable_reg, ram_enable_next;
    logic [cbm_pkg::ROM_BANK_W-1:0]   rom_bank_reg, rom_bank_next;
    logic [cbm_pkg::UPPER_W-1:0]      upper_bits_reg, upper_bits_next;
    logic                             adv_mode_reg, adv_mode_next;
    logic [cbm_pkg::RAM_BANK_W-1:0]   ram_bank_reg, ram_bank_next;

    // Pipeline
    logic          s1_valid_reg;
    cbm_pkg::req_t s1_data_reg;
    logic          out_valid_reg;
    cbm_pkg::rsp_t out_data_reg, out_data_next;
    logic          s1_advance;

    // Decode helpers
    logic                           mbc1, mbc3, mbc5, has_regs;
    logic [cbm_pkg::ADDR_W-1:0]     a;
    logic [cbm_pkg::DATA_W-1:0]     v;
    logic [cbm_pkg::ROM_BANK_W-1:0] rom_bank_sel;
    logic [cbm_pkg::RAM_BANK_W-1:0] ram_bank_sel;

    assign cfg_ready = 1'b1;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapper_type_reg   <= cbm_pkg::MAP_NONE;
            rom_bank_bits_reg <= 4'd1;
            ram_present_reg   <= 1'b0;
            ram_bank_bits_reg <= 3'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cbm_pkg::CFG_MAPPER_TYPE:   mapper_type_reg   <= cfg_data[2:0];
                cbm_pkg::CFG_ROM_BANK_BITS: rom_bank_bits_reg <= cfg_data[3:0];
                cbm_pkg::CFG_RAM_PRESENT:   ram_present_reg   <= cfg_data[0];
                cbm_pkg::CFG_RAM_BANK_BITS: ram_bank_bits_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Mapping and register update for the request in stage 1
    always_comb
    begin
        mbc1     = (mapper_type_reg == cbm_pkg::MAP_MBC1);
        mbc3     = (mapper_type_reg == cbm_pkg::MAP_MBC3);
        mbc5     = (mapper_type_reg == cbm_pkg::MAP_MBC5);
        has_regs = mbc1 || mbc3 || mbc5;
        a        = s1_data_reg.bus_address;
        v        = s1_data_reg.write_data;

        ram_enable_next = ram_enable_reg;
        rom_bank_next   = rom_bank_reg;
        upper_bits_next = upper_bits_reg;
        adv_mode_next   = adv_mode_reg;
        ram_bank_next   = ram_bank_reg;

        out_data_next.target           = cbm_pkg::TGT_NONE;
        out_data_next.physical_address = '0;
        out_data_next.ram_write        = 1'b0;
        rom_bank_sel = '0;
        ram_bank_sel = '0;

        if (a inside {[16'h0000:16'h7FFF]})
        begin
            if (s1_data_reg.kind == cbm_pkg::KIND_WRITE)
            begin
                // Mapper register write
                if (has_regs)
                begin
                    if (a inside {[16'h0000:16'h1FFF]})
                    begin
                        ram_enable_next = (v[3:0] == cbm_pkg::RAM_EN_KEY);
                    end
                    else if (a inside {[16'h2000:16'h3FFF]})
                    begin
                        if (mbc1)
                        begin
                            rom_bank_next = (v[4:0] == 5'd0) ? 9'd1 : {4'd0, v[4:0]};
                        end
                        else if (mbc3)
                        begin
                            rom_bank_next = (v[6:0] == 7'd0) ? 9'd1 : {2'd0, v[6:0]};
                        end
                        else if (a inside {[16'h2000:16'h2FFF]})
                        begin
                            rom_bank_next = {rom_bank_reg[8], v};
                        end
                        else
                        begin
                            rom_bank_next = {v[0], rom_bank_reg[7:0]};
                        end
                    end
                    else if (a inside {[16'h4000:16'h5FFF]})
                    begin
                        if (mbc1)
                        begin
                            upper_bits_next = v[1:0];
                        end
                        else if (mbc3)
                        begin
                            if (v <= 8'h03)
                            begin
                                ram_bank_next = v[3:0];
                            end
                        end
                        else
                        begin
                            ram_bank_next = v[3:0];
                        end
                    end
                    else if (mbc1)
                    begin
                        adv_mode_next = v[0];
                    end
                end
            end
            else
            begin
                // ROM read: fixed area then switchable area
                if (!a[14])
                begin
                    rom_bank_sel = (mbc1 && adv_mode_reg) ? {2'd0, upper_bits_reg, 5'd0} : '0;
                end
                else
                begin
                    rom_bank_sel = mbc1 ? {2'd0, upper_bits_reg, rom_bank_reg[4:0]}
                                        : rom_bank_reg;
                end
                out_data_next.target = cbm_pkg::TGT_ROM;
                out_data_next.physical_address =
                    {rom_bank_sel & cbm_pkg::rom_mask(rom_bank_bits_reg),
                     a[cbm_pkg::ROM_OFS_W-1:0]};
            end
        end
        else if (a inside {[16'hA000:16'hBFFF]})
        begin
            // External RAM window
            if (!ram_enable_reg || !ram_present_reg)
            begin
                out_data_next.target = cbm_pkg::TGT_OPEN;
            end
            else
            begin
                if (mbc1)
                begin
                    ram_bank_sel = adv_mode_reg ? {2'd0, upper_bits_reg} : '0;
                end
                else
                begin
                    ram_bank_sel = ram_bank_reg;
                end
                out_data_next.target = cbm_pkg::TGT_RAM;
                out_data_next.physical_address =
                    {6'd0, ram_bank_sel & cbm_pkg::ram_mask(ram_bank_bits_reg),
                     a[cbm_pkg::RAM_OFS_W-1:0]};
                out_data_next.ram_write = (s1_data_reg.kind == cbm_pkg::KIND_WRITE);
            end
        end
    end

    // Control and bank state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            ram_enable_reg <= 1'b0;
            rom_bank_reg   <= 9'd1;
            upper_bits_reg <= '0;
            adv_mode_reg   <= 1'b0;
            ram_bank_reg   <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                out_valid_reg  <= 1'b1;
                ram_enable_reg <= ram_enable_next;
                rom_bank_reg   <= rom_bank_next;
                upper_bits_reg <= upper_bits_next;
                adv_mode_reg   <= adv_mode_next;
                ram_bank_reg   <= ram_bank_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // RAM write strobe only ever goes with a RAM target
    a_ram_write_target: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.ram_write |-> out_data_reg.target == cbm_pkg::TGT_RAM)
        else $error("ram_write without RAM target");

    // No address for register writes, non-cartridge or open bus
    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.target == cbm_pkg::TGT_NONE ||
                          out_data_reg.target == cbm_pkg::TGT_OPEN)
        |-> out_data_reg.physical_address == '0)
        else $error("nonzero address on non-mapped result");

    // An empty result register never stalls the input side
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    // A stalled stage-1 request is held intact
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_data_reg))
        else $error("stage 1 request lost or changed while stalled");

    // Bank state changes only when a request passes to the result register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_advance |=> $stable(rom_bank_reg) && $stable(ram_bank_reg) &&
                        $stable(ram_enable_reg))
        else $error("bank state changed without a request");

endmodule

// File: bench/cbm_map_checker.sv
`timescale 1ns / 100ps

module cbm_map_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  cbm_pkg::req_t                  in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  cbm_pkg::rsp_t                  out_data,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             error_count,
    output int                             pending
);

    // Shadow configuration
    logic [2:0] cfg_mapper;
    logic [3:0] cfg_rom_bits;
    logic       cfg_ram_present;
    logic [2:0] cfg_ram_bits;

    // Shadow bank registers
    logic       bank_ram_en;
    logic [8:0] bank_rom;
    logic [1:0] bank_upper;
    logic       bank_adv;
    logic [3:0] bank_ram;

    // Results still owed by the block, oldest first
    cbm_pkg::rsp_t expected_maps[$];
    int            mismatches;

    // ROM bank mask, bank count capped at 512
    function automatic logic [8:0] rom_bank_mask();
        int b;
        b = (cfg_rom_bits > 4'd9) ? 9 : int'(cfg_rom_bits);
        return 9'((1 << b) - 1);
    endfunction

    // RAM bank mask, bank count capped at 16
    function automatic logic [3:0] ram_bank_mask();
        int b;
        b = (cfg_ram_bits > 3'd4) ? 4 : int'(cfg_ram_bits);
        return 4'((1 << b) - 1);
    endfunction

    // Register write into the ROM area, per mapper rules
    function automatic void update_banks(input logic [15:0] a, input logic [7:0] v);
        logic is1;
        logic is3;
        logic is5;
        is1 = (cfg_mapper == cbm_pkg::MAP_MBC1);
        is3 = (cfg_mapper == cbm_pkg::MAP_MBC3);
        is5 = (cfg_mapper == cbm_pkg::MAP_MBC5);
        if (!(is1 || is3 || is5))
            return;
        if (a <= 16'h1FFF)
        begin
            bank_ram_en = (v[3:0] == cbm_pkg::RAM_EN_KEY);
        end
        else if (a <= 16'h3FFF)
        begin
            if (is1)
            begin
                bank_rom = {4'd0, v[4:0]};
                if (v[4:0] == 5'd0)
                    bank_rom = 9'd1;
            end
            else if (is3)
            begin
                bank_rom = {2'd0, v[6:0]};
                if (v[6:0] == 7'd0)
                    bank_rom = 9'd1;
            end
            else if (a <= 16'h2FFF)
            begin
                bank_rom = {bank_rom[8], v};
            end
            else
            begin
                bank_rom = {v[0], bank_rom[7:0]};
            end
        end
        else if (a <= 16'h5FFF)
        begin
            if (is1)
                bank_upper = v[1:0];
            else if (is3)
            begin
                // selects above 3 would be RTC registers
                if (v <= 8'h03)
                    bank_ram = v[3:0];
            end
            else
                bank_ram = v[3:0];
        end
        else if (is1)
        begin
            bank_adv = v[0];
        end
    endfunction

    // Map one bus request; register writes update the shadow banks
    function automatic cbm_pkg::rsp_t map_access(input cbm_pkg::req_t r);
        cbm_pkg::rsp_t res;
        logic          is1;
        logic [8:0]    rom_sel;
        logic [3:0]    ram_sel;
        res = '0;
        is1 = (cfg_mapper == cbm_pkg::MAP_MBC1);
        if (!r.bus_address[15])
        begin
            if (r.kind == cbm_pkg::KIND_WRITE)
            begin
                update_banks(r.bus_address, r.write_data);
            end
            else
            begin
                if (!r.bus_address[14])
                    rom_sel = (is1 && bank_adv) ? {2'd0, bank_upper, 5'd0} : 9'd0;
                else
                    rom_sel = is1 ? {2'd0, bank_upper, bank_rom[4:0]} : bank_rom;
                rom_sel &= rom_bank_mask();
                res.target = cbm_pkg::TGT_ROM;
                res.physical_address = {rom_sel, r.bus_address[13:0]};
            end
        end
        else if (r.bus_address >= 16'hA000 && r.bus_address <= 16'hBFFF)
        begin
            if (!bank_ram_en || !cfg_ram_present)
            begin
                res.target = cbm_pkg::TGT_OPEN;
            end
            else
            begin
                if (is1)
                    ram_sel = bank_adv ? {2'd0, bank_upper} : 4'd0;
                else
                    ram_sel = bank_ram;
                ram_sel &= ram_bank_mask();
                res.target = cbm_pkg::TGT_RAM;
                res.physical_address = {6'd0, ram_sel, r.bus_address[12:0]};
                res.ram_write = r.kind;
            end
        end
        return res;
    endfunction

    // Watch all three channels
    always @(posedge clk or negedge rst_n)
    begin : watch
        cbm_pkg::rsp_t exp_map;
        if (!rst_n)
        begin
            cfg_mapper      = cbm_pkg::MAP_NONE;
            cfg_rom_bits    = 4'd1;
            cfg_ram_present = 1'b0;
            cfg_ram_bits    = 3'd0;
            bank_ram_en     = 1'b0;
            bank_rom        = 9'd1;
            bank_upper      = 2'd0;
            bank_adv        = 1'b0;
            bank_ram        = 4'd0;
            expected_maps.delete();
            mismatches      = 0;
            error_count    <= 0;
            pending        <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cbm_pkg::CFG_MAPPER_TYPE:   cfg_mapper      = cfg_data[2:0];
                    cbm_pkg::CFG_ROM_BANK_BITS: cfg_rom_bits    = cfg_data;
                    cbm_pkg::CFG_RAM_PRESENT:   cfg_ram_present = cfg_data[0];
                    cbm_pkg::CFG_RAM_BANK_BITS: cfg_ram_bits    = cfg_data[2:0];
                    default: ;
                endcase
            end

            // compare the result before queuing this edge's request
            if (out_valid && out_ready)
            begin
                if (expected_maps.size() == 0)
                begin
                    $error("result with no request outstanding: target %0d addr %h",
                           out_data.target, out_data.physical_address);
                    mismatches++;
                end
                else
                begin
                    exp_map = expected_maps.pop_front();
                    if (out_data.target !== exp_map.target)
                    begin
                        $error("target mismatch: expected %0d, got %0d",
                               exp_map.target, out_data.target);
                        mismatches++;
                    end
                    if (out_data.physical_address !== exp_map.physical_address)
                    begin
                        $error("physical_address mismatch: expected %h, got %h",
                               exp_map.physical_address, out_data.physical_address);
                        mismatches++;
                    end
                    if (out_data.ram_write !== exp_map.ram_write)
                    begin
                        $error("ram_write mismatch: expected %0d, got %0d",
                               exp_map.ram_write, out_data.ram_write);
                        mismatches++;
                    end
                end
            end

            if (in_valid && in_ready)
                expected_maps.insert(expected_maps.size(), map_access(in_data));

            error_count <= mismatches;
            pending     <= expected_maps.size();
        end
    end

endmodule

// File: bench/cartridge_bank_mapper_unit_tb.sv
`timescale 1ns / 100ps

module cartridge_bank_mapper_unit_tb;

    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 72;
    localparam int HOLD_CYCLES   = 200;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    cbm_pkg::req_t                  in_data;
    logic                           out_valid;
    logic                           out_ready;
    cbm_pkg::rsp_t                  out_data;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data;

    int            error_count;
    int            pending;
    int            hold_pulses;
    int            burst_left;
    bit            gap_free;
    cbm_pkg::req_t script[$];

    cartridge_bank_mapper_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cbm_map_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .pending     (pending)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: changing stall pattern, plus one long hold-off on request
    initial
    begin : rx_pattern
        int mode;
        int left;
        int seen;
        mode = 0;
        left = 0;
        seen = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pulses != seen)
            begin
                seen = hold_pulses;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ((left % 5) < 3);
            endcase
        end
    end

    // Offer one request; bursts of random length with gaps between them unless gap_free
    task automatic send_access(input cbm_pkg::req_t r);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (!gap_free)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stop offering and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all four registers; only called while idle
    task automatic configure(input logic [3:0] v_map, input logic [3:0] v_rom,
                             input logic [3:0] v_present, input logic [3:0] v_ram);
        logic [cbm_pkg::CFG_IDX_W-1:0]  idx  [4];
        logic [cbm_pkg::CFG_DATA_W-1:0] vals [4];
        idx[0]  = cbm_pkg::CFG_MAPPER_TYPE;
        idx[1]  = cbm_pkg::CFG_ROM_BANK_BITS;
        idx[2]  = cbm_pkg::CFG_RAM_PRESENT;
        idx[3]  = cbm_pkg::CFG_RAM_BANK_BITS;
        vals[0] = v_map;
        vals[1] = v_rom;
        vals[2] = v_present;
        vals[3] = v_ram;
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic void plan(input logic k, input logic [15:0] a, input logic [7:0] d);
        cbm_pkg::req_t r;
        r.kind        = k;
        r.bus_address = a;
        r.write_data  = d;
        script.insert(script.size(), r);
    endfunction

    task automatic run_script();
        foreach (script[i])
            send_access(script[i]);
        script.delete();
        drain();
    endtask

    // Mostly bank-register writes, ROM reads and RAM accesses; some noise
    function automatic cbm_pkg::req_t random_access();
        cbm_pkg::req_t r;
        int            pick;
        pick         = $urandom_range(0, 99);
        r.write_data = 8'($urandom);
        if (pick < 30)
        begin
            r.kind        = cbm_pkg::KIND_WRITE;
            r.bus_address = 16'($urandom_range(0, 16'h7FFF));
            case ($urandom_range(0, 3))
                0:       r.write_data = {4'($urandom), cbm_pkg::RAM_EN_KEY};
                1:       r.write_data = 8'($urandom_range(0, 4));
                default: ;
            endcase
        end
        else if (pick < 60)
        begin
            r.kind        = cbm_pkg::KIND_READ;
            r.bus_address = 16'($urandom_range(0, 16'h7FFF));
        end
        else if (pick < 85)
        begin
            r.kind        = 1'($urandom);
            r.bus_address = 16'($urandom_range(16'hA000, 16'hBFFF));
        end
        else
        begin
            r.kind        = 1'($urandom);
            r.bus_address = 16'($urandom);
        end
        return r;
    endfunction

    // Stimulus
    initial
    begin : stimulus
        logic [2:0] map_sel;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        rst_n       <= 1'b0;
        hold_pulses <= 0;
        burst_left  = 0;
        gap_free    = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // MBC1: ROM area bounds, disabled RAM, bank zero fix-up, advanced mode
        configure({1'b0, cbm_pkg::MAP_MBC1}, 4'd9, 4'd1, 4'd2);
        plan(cbm_pkg::KIND_READ,  16'h0000, 8'h00);
        plan(cbm_pkg::KIND_READ,  16'h3FFF, 8'h00);
        plan(cbm_pkg::KIND_READ,  16'h4000, 8'h00);
        plan(cbm_pkg::KIND_READ,  16'h7FFF, 8'h00);
        plan(cbm_pkg::KIND_READ,  16'hA000, 8'h00);
        plan(cbm_pkg::KIND_WRITE, 16'hBFFF, 8'hFF);
        plan(cbm_pkg::KIND_WRITE, 16'h0000, 8'h3A);
        plan(cbm_pkg::KIND_WRITE, 16'h2000, 8'h00);
        plan(cbm_pkg::KIND_WRITE, 16'h3FFF, 8'hFF);
        plan(cbm_pkg::KIND_WRITE, 16'h4000, 8'h03);
        plan(cbm_pkg::KIND_WRITE, 16'h6000, 8'h01);
        plan(cbm_pkg::KIND_READ,  16'h0000, 8'h00);
        plan(cbm_pkg::KIND_READ,  16'h7FFF, 8'h00);
        plan(cbm_pkg::KIND_WRITE, 16'hA000, 8'h55);
        plan(cbm_pkg::KIND_READ,  16'hBFFF, 8'h00);
        plan(cbm_pkg::KIND_READ,  16'h8000, 8'h00);
        plan(cbm_pkg::KIND_WRITE, 16'hFFFF, 8'hFF);
        plan(cbm_pkg::KIND_WRITE, 16'h1FFF, 8'h00);
        plan(cbm_pkg::KIND_READ,  16'hA000, 8'h00);
        run_script();

        // MBC5 with oversized bank counts: 9-bit ROM bank, RAM bank 15
        configure({1'b0, cbm_pkg::MAP_MBC5}, 4'd12, 4'd1, 4'd7);
        plan(cbm_pkg::KIND_WRITE, 16'h0000, 8'h0A);
        plan(cbm_pkg::KIND_WRITE, 16'h2FFF, 8'hFF);
        plan(cbm_pkg::KIND_WRITE, 16'h3000, 8'h01);
        plan(cbm_pkg::KIND_READ,  16'h7FFF, 8'h00);
        plan(cbm_pkg::KIND_WRITE, 16'h5FFF, 8'hFF);
        plan(cbm_pkg::KIND_WRITE, 16'hBFFF, 8'h00);
        run_script();

        // MBC3: RTC select ignored, zero bank fix-up
        configure({1'b0, cbm_pkg::MAP_MBC3}, 4'd1, 4'd1, 4'd4);
        plan(cbm_pkg::KIND_WRITE, 16'h4000, 8'h04);
        plan(cbm_pkg::KIND_WRITE, 16'h2000, 8'h80);
        plan(cbm_pkg::KIND_READ,  16'h4000, 8'h00);
        plan(cbm_pkg::KIND_READ,  16'hA000, 8'h00);
        run_script();

        // Random phases; first ones at the extremes of the settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: configure({1'b0, cbm_pkg::MAP_MBC1}, 4'd9,  4'd1, 4'd4);
                1: configure({1'b0, cbm_pkg::MAP_MBC3}, 4'd1,  4'd1, 4'd0);
                2: configure({1'b0, cbm_pkg::MAP_MBC5}, 4'd9,  4'd1, 4'd4);
                3: configure({1'b0, cbm_pkg::MAP_MBC1}, 4'd15, 4'd1, 4'd7);
                4: configure({1'b0, cbm_pkg::MAP_MBC5}, 4'd0,  4'd0, 4'd2);
                5: configure({1'b0, cbm_pkg::MAP_MBC3}, 4'd7,  4'd1, 4'd2);
                default:
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: map_sel = cbm_pkg::MAP_MBC1;
                        3, 4:    map_sel = cbm_pkg::MAP_MBC3;
                        5, 6:    map_sel = cbm_pkg::MAP_MBC5;
                        default: map_sel = 3'($urandom);
                    endcase
                    configure({1'($urandom), map_sel}, 4'($urandom),
                              {3'($urandom), ($urandom_range(0, 3) != 0)},
                              4'($urandom));
                end
            endcase
            gap_free = (p % 4 == 3) || (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // long result-side hold-off while requests keep coming
                if (p == 2 && i == 8)
                    hold_pulses <= hold_pulses + 1;
                send_access(random_access());
            end
            drain();
        end

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
